>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the strict priority request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned CNT_W = 9;   // counts, depths and max_depth
  localparam int unsigned ID_W  = 8;   // request id field
  localparam int unsigned SEQ_W = 32;  // sequence number field
  localparam int unsigned CTX_W = 8;   // context tag field
  localparam int unsigned TYP_W = 4;   // request type field
  localparam int unsigned PRI_W = 3;   // priority field
  localparam int unsigned CMP_W = 11;  // width for id range compares

  // Request type codes
  typedef enum logic [TYP_W-1:0] {
    REQ_ENQ      = 4'd0,
    REQ_DEQ_HI   = 4'd1,
    REQ_DEQ_PRI  = 4'd2,
    REQ_REMOVE   = 4'd3,
    REQ_FIND_SEQ = 4'd4,
    REQ_FIND_CTX = 4'd5,
    REQ_CLEAR    = 4'd6,
    REQ_RST_PEAK = 4'd7,
    REQ_QUERY    = 4'd8
  } req_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ENQ_LINK,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_FIND_LVL,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_DONE
  } state_e;

  // Key handed to the compare unit
  typedef struct packed {
    logic             by_ctx;
    logic [SEQ_W-1:0] seqno;
    logic [CTX_W-1:0] ctx;
  } match_req_t;

endpackage

`default_nettype wire

>>> rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/spq_match.sv
// ----------------------------------------------------------------------------
// spq_match
// Search compare unit: stored seqno or context tag against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_match (
  input  wire spq_pkg::match_req_t             key_i,
  input  wire logic [spq_pkg::SEQ_W-1:0]       slot_seqno_i,
  input  wire logic [spq_pkg::CTX_W-1:0]       slot_ctx_i,
  output logic                                 hit_o
);

  import spq_pkg::*;

  // One compare per walk step, mode picked by the search type
  assign hit_o = key_i.by_ctx ? (slot_ctx_i == key_i.ctx) : (slot_seqno_i == key_i.seqno);

endmodule

`default_nettype wire

>>> rtl/strict_priority_request_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_request_queue
// Per-priority FIFOs of request ids, linked through a slot store in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request transaction:
//   type, id, priority, seqno and context. Output channel (out_valid_o/
//   out_ready_i) returns one result transaction per request: status, id,
//   counts, peak depth and the current head.
//   Config channel (cfg_valid_i/cfg_ready_o) writes max_depth; always ready,
//   write only while the block is idle.
//   Enqueue links a non-empty list's old tail in an extra step; dequeue
//   and remove read the neighbour pointers, then splice them. Find visits
//   the levels in turn and compares their entries in list order until a
//   hit. Each list step of the sequencer is one registered read of the
//   next-pointer and slot data RAMs, then one compare.
//   Reset: all queues empty, peak 0, max_depth 256; no clearing pass, the
//   queued bits are flip-flops and the RAM contents are read only for
//   queued ids.
//   A stalled receiver holds the result register; one further request is
//   accepted and processed, then the sequencer waits to hand its result over.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_priority_request_queue #(
  parameter int unsigned PRIORITY_LEVELS = 4,
  parameter int unsigned NUM_REQUESTS    = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [spq_pkg::CNT_W-1:0]   cfg_data_i,
  // request
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [spq_pkg::TYP_W-1:0]   req_type_i,
  input  wire logic [spq_pkg::ID_W-1:0]    request_id_i,
  input  wire logic [spq_pkg::PRI_W-1:0]   priority_req_i,
  input  wire logic [spq_pkg::SEQ_W-1:0]   seqno_i,
  input  wire logic [spq_pkg::CTX_W-1:0]   context_id_i,
  // result
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             ok_o,
  output logic [spq_pkg::ID_W-1:0]         result_id_o,
  output logic [spq_pkg::CNT_W-1:0]        total_count_o,
  output logic [spq_pkg::CNT_W-1:0]        priority_count_o,
  output logic [spq_pkg::CNT_W-1:0]        peak_depth_o,
  output logic                             head_valid_o,
  output logic [spq_pkg::ID_W-1:0]         head_id_o
);

  import spq_pkg::*;

  localparam int unsigned AW  = $clog2(NUM_REQUESTS);
  localparam int unsigned PW  = $clog2(NUM_REQUESTS + 1);
  localparam int unsigned LW  = $clog2(PRIORITY_LEVELS);
  localparam int unsigned LCW = $clog2(PRIORITY_LEVELS + 1);
  localparam int unsigned DW  = SEQ_W + CTX_W + LW;
  localparam logic [PW-1:0] NIL = PW'(NUM_REQUESTS);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e st_q, st_d;

  logic [TYP_W-1:0] req_q;
  logic [ID_W-1:0]  rid_q;
  logic [PRI_W-1:0] prio_q;
  logic [SEQ_W-1:0] seq_q;
  logic [CTX_W-1:0] ctx_q;

  logic             ok_q, ok_d;
  logic [PW-1:0]    res_q, res_d;
  logic [PW-1:0]    cur_q, cur_d;
  logic [PW-1:0]    tail_t_q, tail_t_d;
  logic [LCW-1:0]   lv_q, lv_d;
  logic [CNT_W-1:0] steps_q, steps_d;

  logic [PW-1:0]    head_q [PRIORITY_LEVELS];
  logic [PW-1:0]    head_d [PRIORITY_LEVELS];
  logic [PW-1:0]    tail_q [PRIORITY_LEVELS];
  logic [PW-1:0]    tail_d [PRIORITY_LEVELS];
  logic [CNT_W-1:0] cnt_q  [PRIORITY_LEVELS];
  logic [CNT_W-1:0] cnt_d  [PRIORITY_LEVELS];
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [CNT_W-1:0] max_depth_q;
  logic [NUM_REQUESTS-1:0] queued_q, queued_d;

  logic             ov_q;
  logic             o_ok_q;
  logic [ID_W-1:0]  o_res_q;
  logic [CNT_W-1:0] o_total_q, o_pcnt_q, o_peak_q;
  logic             o_hv_q;
  logic [ID_W-1:0]  o_hid_q;

  // RAM ports
  logic          d_we;
  logic [AW-1:0] d_waddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic          n_we;
  logic [AW-1:0] n_waddr;
  logic [PW-1:0] n_wdata, n_rdata;
  logic          p_we;
  logic [AW-1:0] p_waddr;
  logic [PW-1:0] p_wdata, p_rdata;
  logic [AW-1:0] raddr;

  // --------------------------------------------------------------------------
  // Decodes
  // --------------------------------------------------------------------------
  logic          prio_ok;
  logic [LW-1:0] pl;
  logic          rid_ok;
  logic [AW-1:0] rid_a;
  logic          hi_found;
  logic [LW-1:0] hi_lv;
  logic [LW-1:0] lvi;
  logic          lv_end;
  logic [LW-1:0] slot_lv;
  logic          hit;
  match_req_t    mkey;

  assign prio_ok = 4'(prio_q) < 4'(PRIORITY_LEVELS);
  assign pl      = prio_q[LW-1:0];
  assign rid_ok  = CMP_W'(rid_q) < CMP_W'(NUM_REQUESTS);
  assign rid_a   = AW'(rid_q);
  assign lvi     = lv_q[LW-1:0];
  assign lv_end  = lv_q == LCW'(PRIORITY_LEVELS);
  assign slot_lv = d_rdata[LW-1:0];
  assign raddr   = cur_q[AW-1:0];

  // highest non-empty level
  always_comb begin
    hi_found = 1'b0;
    hi_lv    = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (cnt_q[i] != '0 && head_q[i] < NIL) begin
        hi_found = 1'b1;
        hi_lv    = LW'(i);
      end
    end
  end

  // search key for the compare unit
  assign mkey.by_ctx = req_q == REQ_FIND_CTX;
  assign mkey.seqno  = seq_q;
  assign mkey.ctx    = ctx_q;

  spq_match u_match (
    .key_i        (mkey),
    .slot_seqno_i (d_rdata[DW-1 -: SEQ_W]),
    .slot_ctx_i   (d_rdata[LW +: CTX_W]),
    .hit_o        (hit)
  );

  // --------------------------------------------------------------------------
  // Slot store: data, next pointers, prev pointers
  // --------------------------------------------------------------------------
  spq_ram #(.WIDTH(DW), .DEPTH(NUM_REQUESTS)) u_data_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(raddr), .rdata_o(d_rdata)
  );

  spq_ram #(.WIDTH(PW), .DEPTH(NUM_REQUESTS)) u_next_ram (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(raddr), .rdata_o(n_rdata)
  );

  spq_ram #(.WIDTH(PW), .DEPTH(NUM_REQUESTS)) u_prev_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(raddr), .rdata_o(p_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_EXEC;
      ST_EXEC: begin
        st_d = ST_DONE;
        unique case (req_q)
          REQ_ENQ: begin
            if (prio_ok && rid_ok && !queued_q[rid_a] && total_q < max_depth_q &&
                cnt_q[pl] != '0 && tail_q[pl] < NIL) st_d = ST_ENQ_LINK;
          end
          REQ_DEQ_HI:   if (hi_found) st_d = ST_UNL_RD;
          REQ_DEQ_PRI:  if (prio_ok && cnt_q[pl] != '0 && head_q[pl] < NIL) st_d = ST_UNL_RD;
          REQ_REMOVE:   if (rid_ok && queued_q[rid_a]) st_d = ST_UNL_RD;
          REQ_FIND_SEQ: st_d = ST_FIND_LVL;
          REQ_FIND_CTX: st_d = ST_FIND_LVL;
          default:      st_d = ST_DONE;
        endcase
      end
      ST_ENQ_LINK: st_d = ST_DONE;
      ST_UNL_RD:   st_d = ST_UNL_WR;
      ST_UNL_WR:   st_d = ST_DONE;
      ST_FIND_LVL: st_d = lv_end ? ST_DONE : ST_FIND_RD;
      ST_FIND_RD:  st_d = (steps_q < cnt_q[lvi] && cur_q < NIL) ? ST_FIND_CMP : ST_FIND_LVL;
      ST_FIND_CMP: st_d = hit ? ST_DONE : ST_FIND_RD;
      ST_DONE:     if (!ov_q || out_ready_i) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    ok_d     = ok_q;
    res_d    = res_q;
    cur_d    = cur_q;
    tail_t_d = tail_t_q;
    lv_d     = lv_q;
    steps_d  = steps_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    peak_d   = peak_q;
    queued_d = queued_q;
    d_we     = 1'b0;
    d_waddr  = rid_a;
    d_wdata  = {seq_q, ctx_q, pl};
    n_we     = 1'b0;
    n_waddr  = rid_a;
    n_wdata  = NIL;
    p_we     = 1'b0;
    p_waddr  = rid_a;
    p_wdata  = NIL;

    unique case (st_q)
      ST_EXEC: begin
        ok_d  = 1'b0;
        res_d = '0;
        unique case (req_q)
          REQ_ENQ: begin
            if (prio_ok && rid_ok && !queued_q[rid_a] && total_q < max_depth_q) begin
              d_we     = 1'b1;
              n_we     = 1'b1;
              p_we     = 1'b1;
              p_wdata  = (cnt_q[pl] != '0) ? tail_q[pl] : NIL;
              tail_t_d = tail_q[pl];
              if (!(cnt_q[pl] != '0 && tail_q[pl] < NIL)) head_d[pl] = PW'(rid_q);
              tail_d[pl]      = PW'(rid_q);
              queued_d[rid_a] = 1'b1;
              cnt_d[pl]       = cnt_q[pl] + 1'b1;
              total_d         = total_q + 1'b1;
              if (total_q + 1'b1 > peak_q) peak_d = total_q + 1'b1;
              ok_d  = 1'b1;
              res_d = PW'(rid_q);
            end
          end
          REQ_DEQ_HI: begin
            cur_d = head_q[hi_lv];
            ok_d  = hi_found;
            res_d = hi_found ? head_q[hi_lv] : '0;
          end
          REQ_DEQ_PRI: begin
            if (prio_ok && cnt_q[pl] != '0 && head_q[pl] < NIL) begin
              cur_d = head_q[pl];
              ok_d  = 1'b1;
              res_d = head_q[pl];
            end
          end
          REQ_REMOVE: begin
            if (rid_ok && queued_q[rid_a]) begin
              cur_d = PW'(rid_q);
              ok_d  = 1'b1;
              res_d = PW'(rid_q);
            end
          end
          REQ_FIND_SEQ, REQ_FIND_CTX: lv_d = '0;
          REQ_CLEAR: begin
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
              head_d[i] = NIL;
              tail_d[i] = NIL;
              cnt_d[i]  = '0;
            end
            queued_d = '0;
            total_d  = '0;
            ok_d     = 1'b1;
          end
          REQ_RST_PEAK: begin
            peak_d = '0;
            ok_d   = 1'b1;
          end
          REQ_QUERY: ok_d = 1'b1;
          default:   ok_d = 1'b0;
        endcase
      end
      // link old tail forward to the new id
      ST_ENQ_LINK: begin
        n_we    = 1'b1;
        n_waddr = tail_t_q[AW-1:0];
        n_wdata = PW'(rid_q);
      end
      // splice neighbours of cur around it
      ST_UNL_WR: begin
        if (4'(slot_lv) < 4'(PRIORITY_LEVELS)) begin
          if (p_rdata < NIL) begin
            n_we    = 1'b1;
            n_waddr = p_rdata[AW-1:0];
            n_wdata = n_rdata;
          end else begin
            head_d[slot_lv] = n_rdata;
          end
          if (n_rdata < NIL) begin
            p_we    = 1'b1;
            p_waddr = n_rdata[AW-1:0];
            p_wdata = p_rdata;
          end else begin
            tail_d[slot_lv] = p_rdata;
          end
          queued_d[cur_q[AW-1:0]] = 1'b0;
          if (cnt_q[slot_lv] != '0) cnt_d[slot_lv] = cnt_q[slot_lv] - 1'b1;
          if (total_q != '0) total_d = total_q - 1'b1;
        end
      end
      ST_FIND_LVL: begin
        if (!lv_end) begin
          cur_d   = head_q[lvi];
          steps_d = '0;
        end
      end
      ST_FIND_RD: begin
        if (!(steps_q < cnt_q[lvi] && cur_q < NIL)) lv_d = lv_q + 1'b1;
      end
      ST_FIND_CMP: begin
        if (hit) begin
          ok_d  = 1'b1;
          res_d = cur_q;
        end else begin
          cur_d   = n_rdata;
          steps_d = steps_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      total_q     <= '0;
      peak_q      <= '0;
      max_depth_q <= CNT_W'(256);
      queued_q    <= '0;
      ov_q        <= 1'b0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
        cnt_q[i]  <= '0;
      end
    end else begin
      st_q     <= st_d;
      total_q  <= total_d;
      peak_q   <= peak_d;
      queued_q <= queued_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      if (cfg_valid_i) max_depth_q <= cfg_data_i;
      if (st_q == ST_DONE && (!ov_q || out_ready_i)) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // request capture and walk registers
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      req_q  <= req_type_i;
      rid_q  <= request_id_i;
      prio_q <= priority_req_i;
      seq_q  <= seqno_i;
      ctx_q  <= context_id_i;
    end
    ok_q     <= ok_d;
    res_q    <= res_d;
    cur_q    <= cur_d;
    tail_t_q <= tail_t_d;
    lv_q     <= lv_d;
    steps_q  <= steps_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (st_q == ST_DONE && (!ov_q || out_ready_i)) begin
      o_ok_q    <= ok_q;
      o_res_q   <= ok_q ? ID_W'(res_q) : '0;
      o_total_q <= total_q;
      o_pcnt_q  <= prio_ok ? cnt_q[pl] : '0;
      o_peak_q  <= peak_q;
      o_hv_q    <= hi_found;
      o_hid_q   <= hi_found ? ID_W'(head_q[hi_lv]) : '0;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = st_q == ST_IDLE;
  assign out_valid_o      = ov_q;
  assign ok_o             = o_ok_q;
  assign result_id_o      = o_res_q;
  assign total_count_o    = o_total_q;
  assign priority_count_o = o_pcnt_q;
  assign peak_depth_o     = o_peak_q;
  assign head_valid_o     = o_hv_q;
  assign head_id_o        = o_hid_q;

endmodule

`default_nettype wire

>>> rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result channel of the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic                      ok_o,
  input wire logic [spq_pkg::ID_W-1:0]  result_id_o,
  input wire logic [spq_pkg::CNT_W-1:0] total_count_o,
  input wire logic                      head_valid_o,
  input wire logic [spq_pkg::ID_W-1:0]  head_id_o
);

  import spq_pkg::*;

  // a failed transaction reports no id
  a_fail_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> result_id_o == '0)
    else $error("failed transaction with nonzero id");

  // empty queue shows no head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_count_o == '0 |-> !head_valid_o)
    else $error("head shown with empty queue");

  a_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !head_valid_o |-> head_id_o == '0 && total_count_o == '0)
    else $error("no head but entries or id shown");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_id_o)
      && $stable(total_count_o))
    else $error("stalled result changed");

endmodule

bind strict_priority_request_queue spq_checker u_spq_checker (.*);

`default_nettype wire

>>> dv/strict_priority_request_queue_tb.sv
// ----------------------------------------------------------------------------
// strict_priority_request_queue_tb
// Self-checking bench: a directed table of requests and then random traffic
// are driven into the queue, and each result transaction is compared field by
// field against a behavioural model of the per-priority linked lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strict_priority_request_queue_tb;
  import spq_pkg::*;

  localparam int LEVELS   = 4;
  localparam int NUM_IDS  = 256;
  localparam int NIL      = NUM_IDS;
  localparam int N_RANDOM = 1670;
  localparam int MAX_CYC  = 5000000;
  localparam int MAX_SHOWN = 10;
  localparam logic [3:0] REQ_BAD = 4'd15;

  typedef struct packed {
    logic [TYP_W-1:0] typ;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [SEQ_W-1:0] seq;
    logic [CTX_W-1:0] ctx;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [ID_W-1:0]  rid;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] pcount;
    logic [CNT_W-1:0] peak;
    logic             hvalid;
    logic [ID_W-1:0]  hid;
  } res_t;

  // directed table row: request plus an optional typed-in result
  typedef struct packed {
    req_t req;
    logic known;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_res;

  // queue model state
  logic [SEQ_W-1:0] m_seq [NUM_IDS];
  logic [CTX_W-1:0] m_ctx [NUM_IDS];
  int               m_lvl [NUM_IDS];
  bit               m_queued [NUM_IDS];
  int               m_next [NUM_IDS];
  int               m_prev [NUM_IDS];
  int               m_head [LEVELS];
  int               m_tail [LEVELS];
  int               m_cnt [LEVELS];
  int               m_total, m_peak, m_max_depth;

  res_t pending_results[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   rx_idle_on = 1'b1;

  strict_priority_request_queue uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(in_req.typ), .request_id_i(in_req.id),
    .priority_req_i(in_req.pri), .seqno_i(in_req.seq), .context_id_i(in_req.ctx),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .ok_o(out_res.ok), .result_id_o(out_res.rid), .total_count_o(out_res.total),
    .priority_count_o(out_res.pcount), .peak_depth_o(out_res.peak),
    .head_valid_o(out_res.hvalid), .head_id_o(out_res.hid)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void model_reset();
    for (int i = 0; i < NUM_IDS; i++) begin
      m_queued[i] = 0; m_next[i] = NIL; m_prev[i] = NIL;
      m_seq[i] = '0; m_ctx[i] = '0; m_lvl[i] = 0;
    end
    for (int l = 0; l < LEVELS; l++) begin
      m_head[l] = NIL; m_tail[l] = NIL; m_cnt[l] = 0;
    end
    m_total = 0; m_peak = 0; m_max_depth = 256;
  endfunction

  function automatic void unlink_id(int id);
    int lv, p, n;
    lv = m_lvl[id]; p = m_prev[id]; n = m_next[id];
    if (p != NIL) m_next[p] = n; else m_head[lv] = n;
    if (n != NIL) m_prev[n] = p; else m_tail[lv] = p;
    m_next[id] = NIL; m_prev[id] = NIL; m_queued[id] = 0;
    m_cnt[lv]--; m_total--;
  endfunction

  // linear search in level then list order; by_ctx selects the key
  function automatic bit find_first(bit by_ctx, req_t r, output int id);
    int cur;
    for (int l = 0; l < LEVELS; l++) begin
      cur = m_head[l];
      while (cur != NIL) begin
        if (by_ctx ? (m_ctx[cur] == r.ctx) : (m_seq[cur] == r.seq)) begin
          id = cur;
          return 1;
        end
        cur = m_next[cur];
      end
    end
    return 0;
  endfunction

  // apply one request to the model and return its result
  function automatic res_t queue_apply(req_t r);
    res_t o;
    int id, p;
    bit ok;
    o = '0; ok = 0; id = 0; p = r.pri;
    case (r.typ)
      REQ_ENQ: begin
        if (p < LEVELS && !m_queued[r.id] && m_total < m_max_depth) begin
          id = r.id;
          m_seq[id] = r.seq; m_ctx[id] = r.ctx; m_lvl[id] = p;
          m_next[id] = NIL; m_prev[id] = m_tail[p];
          if (m_tail[p] != NIL) m_next[m_tail[p]] = id; else m_head[p] = id;
          m_tail[p] = id; m_queued[id] = 1; m_cnt[p]++; m_total++;
          if (m_total > m_peak) m_peak = m_total;
          ok = 1;
        end
      end
      REQ_DEQ_HI: begin
        for (int l = LEVELS - 1; l >= 0 && !ok; l--)
          if (m_cnt[l] != 0) begin
            id = m_head[l]; unlink_id(id); ok = 1;
          end
      end
      REQ_DEQ_PRI: begin
        if (p < LEVELS && m_cnt[p] != 0) begin
          id = m_head[p]; unlink_id(id); ok = 1;
        end
      end
      REQ_REMOVE: begin
        if (m_queued[r.id]) begin
          id = r.id; unlink_id(id); ok = 1;
        end
      end
      REQ_FIND_SEQ: ok = find_first(1'b0, r, id);
      REQ_FIND_CTX: ok = find_first(1'b1, r, id);
      REQ_CLEAR: begin
        for (int i = 0; i < NUM_IDS; i++) begin
          m_queued[i] = 0; m_next[i] = NIL; m_prev[i] = NIL;
        end
        for (int l = 0; l < LEVELS; l++) begin
          m_head[l] = NIL; m_tail[l] = NIL; m_cnt[l] = 0;
        end
        m_total = 0; ok = 1;
      end
      REQ_RST_PEAK: begin m_peak = 0; ok = 1; end
      REQ_QUERY: ok = 1;
      default: ok = 0;
    endcase
    o.ok = ok;
    o.rid = ok ? id[ID_W-1:0] : '0;
    o.total = m_total[CNT_W-1:0];
    o.pcount = (p < LEVELS) ? m_cnt[p][CNT_W-1:0] : '0;
    o.peak = m_peak[CNT_W-1:0];
    for (int l = LEVELS - 1; l >= 0; l--)
      if (m_cnt[l] != 0) begin
        o.hvalid = 1'b1; o.hid = m_head[l][ID_W-1:0]; break;
      end
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result %p", out_res);
      end else begin
        want = pending_results.pop_front();
        if (out_res !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result mismatch: expected %p, got %p", want, out_res);
        end
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // sends one transaction; holds valid until accepted
  task automatic send_request(req_t r, bit idle_ok);
    int n;
    if (idle_ok && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 15);
      repeat (n) @(negedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    pending_results.push_back(queue_apply(r));
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_max_depth(int v);
    cfg_data <= v[CNT_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    m_max_depth = v;
  endtask

  function automatic req_t mk(logic [3:0] t, int id, int p, logic [31:0] s, int c);
    req_t r;
    r.typ = t; r.id = id[ID_W-1:0]; r.pri = p[PRI_W-1:0]; r.seq = s;
    r.ctx = c[CTX_W-1:0];
    return r;
  endfunction

  // random request, biased towards a small id pool so that lists get long
  function automatic req_t random_request(int pool);
    req_t r;
    int pick;
    r.id = ID_W'($urandom_range(0, pool - 1));
    r.pri = ($urandom_range(0, 9) == 0) ? PRI_W'($urandom_range(4, 7))
                                        : PRI_W'($urandom_range(0, 3));
    r.seq = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
    r.ctx = ($urandom_range(0, 3) == 0) ? CTX_W'($urandom_range(0, 255))
                                        : CTX_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 40) r.typ = REQ_ENQ;
    else if (pick < 52) r.typ = REQ_DEQ_HI;
    else if (pick < 62) r.typ = REQ_DEQ_PRI;
    else if (pick < 74) r.typ = REQ_REMOVE;
    else if (pick < 84) r.typ = REQ_FIND_SEQ;
    else if (pick < 93) r.typ = REQ_FIND_CTX;
    else if (pick < 94) r.typ = REQ_CLEAR;
    else if (pick < 96) r.typ = REQ_RST_PEAK;
    else if (pick < 98) r.typ = REQ_QUERY;
    else r.typ = TYP_W'($urandom_range(9, 15));
    return r;
  endfunction

  row_t directed[$];

  initial begin
    row_t row;
    req_t r;
    res_t want;
    int depths[5] = '{0, 1, 5, 255, 256};
    model_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; typed results only where obvious from an empty queue
    row = '0; row.req = mk(REQ_QUERY, 0, 0, 0, 0); row.known = 1;
    row.res = '{1'b1, 8'd0, 9'd0, 9'd0, 9'd0, 1'b0, 8'd0}; directed.push_back(row);
    row = '0; row.req = mk(REQ_DEQ_HI, 0, 0, 0, 0); row.known = 1;
    row.res = '0; directed.push_back(row);
    row = '0; row.req = mk(REQ_ENQ, 3, 7, 0, 0); row.known = 1;
    row.res = '0; directed.push_back(row);
    row = '0; row.req = mk(REQ_DEQ_PRI, 0, 4, 0, 0); row.known = 1;
    row.res = '0; directed.push_back(row);
    row = '0; row.req = mk(REQ_REMOVE, 9, 0, 0, 0); row.known = 1;
    row.res = '0; directed.push_back(row);
    row = '0; row.req = mk(REQ_BAD, 0, 0, 0, 0); row.known = 1;
    row.res = '0; directed.push_back(row);
    row = '0; row.req = mk(REQ_ENQ, 255, 3, 32'hFFFF_FFFF, 255); directed.push_back(row);
    row = '0; row.req = mk(REQ_ENQ, 0, 0, 0, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_ENQ, 0, 1, 1, 1); directed.push_back(row);
    row = '0; row.req = mk(REQ_ENQ, 17, 0, 32'hA5A5_5A5A, 8'h5A); directed.push_back(row);
    row = '0; row.req = mk(REQ_ENQ, 170, 2, 32'h5A5A_A5A5, 8'hA5); directed.push_back(row);
    row = '0; row.req = mk(REQ_FIND_SEQ, 0, 0, 32'hFFFF_FFFF, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_FIND_CTX, 0, 2, 0, 8'hA5); directed.push_back(row);
    row = '0; row.req = mk(REQ_FIND_SEQ, 0, 0, 32'h1234_5678, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_REMOVE, 17, 0, 0, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_DEQ_PRI, 0, 2, 0, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_DEQ_HI, 0, 0, 0, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_RST_PEAK, 0, 0, 0, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_CLEAR, 0, 6, 0, 0); directed.push_back(row);
    row = '0; row.req = mk(REQ_QUERY, 0, 5, 0, 0); directed.push_back(row);

    foreach (directed[i]) begin
      send_request(directed[i].req, 1'b0);
      if (directed[i].known) begin
        want = pending_results[$];
        if (want !== directed[i].res) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("row %0d: table %p, model %p", i, directed[i].res, want);
        end
      end
    end
    drain_results();

    // full queue at the largest depth, then a refused enqueue
    for (int i = 0; i < 257; i++)
      send_request(mk(REQ_ENQ, i % 256, i % 4, i, i), 1'b0);
    send_request(mk(REQ_FIND_CTX, 0, 0, 0, 8'd200), 1'b0);
    send_request(mk(REQ_CLEAR, 0, 0, 0, 0), 1'b0);
    drain_results();

    // random phases across max_depth settings, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      write_max_depth(ph < 5 ? depths[ph] : $urandom_range(0, 256));
      for (int k = 0; k < N_RANDOM / 10; k++) begin
        r = random_request(ph == 3 ? 256 : 24);
        send_request(r, ph < 8);
        // sender holds off until the pipe is empty once per phase
        if (k == 50) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
      if (ph == 7) rx_idle_on = 1'b0;
      drain_results();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> strict_priority_request_queue.f
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_match.sv
rtl/strict_priority_request_queue.sv
rtl/spq_checker.sv
dv/strict_priority_request_queue_tb.sv
